### rtl/ech_pkg.sv
// Shared types, constants and helper functions for the evaluation correction history block.
// Used by ech_ctrl, ech_datapath and eval_correction_history_top; depends on nothing else.
package ech_pkg;

   // Table geometry. TABLE_ENTRIES is a power of two; the key index is reduced by its low bits.
   localparam int TABLE_ENTRIES = 16384;
   localparam int KEY_W         = 14;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int ADDR_W        = IDX_W + 1;
   localparam int DEPTH         = 2 * TABLE_ENTRIES;

   localparam int MATE_LIMIT    = 32000;
   localparam int MATE_MAX      = MATE_LIMIT - 1;

   localparam int VAL_W         = 16;

   // Correction sum and entry decay both divide by 1024.
   localparam int CORR_DIV      = 1024;
   localparam int CORR_SHIFT    = $clog2(CORR_DIV);

   // The fifty-move scaler divides by 200 = 8 * 25.
   localparam int SCALE_DIV       = 200;
   localparam int SCALE_PRE_SHIFT = 3;
   localparam int SCALE_POST_DIV  = SCALE_DIV / (2 ** SCALE_PRE_SHIFT);
   localparam int DIV25_SHIFT     = 27;
   localparam int DIV25_MUL       = (2 ** DIV25_SHIFT) / SCALE_POST_DIV;

   // The update bonus divides by 8.
   localparam int BONUS_SHIFT   = 3;

   // Datapath widths, sized to the input ranges.
   localparam int PROD_W   = 25;
   localparam int SUM_W    = 27;
   localparam int WIDE_W   = 26;
   localparam int Y_W      = 22;
   localparam int RECIP_W  = 45;
   localparam int Q_W      = 18;
   localparam int REM_W    = 23;
   localparam int SCALED_W = 19;
   localparam int EPROD_W  = 27;
   localparam int NEW_W    = 19;
   localparam int TOTAL_W  = 20;
   localparam int LIMIT_W  = 10;
   localparam int BONUS_W  = 11;

   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [WIDE_W-1:0]   wide_type;
   typedef logic        [RECIP_W-1:0]  recip_type;
   typedef logic        [REM_W-1:0]    rem_type;
   typedef logic signed [SCALED_W-1:0] scaled_type;
   typedef logic signed [EPROD_W-1:0]  eprod_type;
   typedef logic signed [NEW_W-1:0]    new_type;
   typedef logic signed [TOTAL_W-1:0]  total_type;
   typedef logic signed [VAL_W-1:0]    value_type;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_PAWN_WEIGHT     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NON_PAWN_WEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BONUS_LIMIT     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIFTY_SCALING   = 4'd3;

   typedef struct packed {
      logic [7:0]         pawn_weight;
      logic [7:0]         non_pawn_weight;
      logic [LIMIT_W-1:0] bonus_limit;
      logic [8:0]         fifty_scaling;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pawn_weight:     8'd36,
      non_pawn_weight: 8'd23,
      bonus_limit:     10'd341,
      fifty_scaling:   9'd187
   };

   // Request codes. Code 3 is unused and returns zero.
   typedef enum logic [1:0] {
      REQ_ADJUST = 2'd0,
      REQ_CORR   = 2'd1,
      REQ_UPDATE = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP1,
      ST_STEP2,
      ST_STEP3,
      ST_STEP4,
      ST_STEP5,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_wr;
      logic table_wr;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_busy;
      logic is_update;
   } status_type;

   function automatic logic [ADDR_W-1:0] table_addr(input logic side,
                                                    input logic [KEY_W-1:0] key);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(key);
      return {side, idx};
   endfunction

   // New entry = entry + bonus - trunc(entry*|bonus| / 1024), saturated to 16 bits.
   function automatic value_type apply_bonus(input value_type entry,
                                             input logic signed [BONUS_W-1:0] bonus,
                                             input eprod_type eprod);
      eprod_type adj;
      value_type decay;
      new_type   sum;
      adj   = eprod + (eprod[EPROD_W-1] ? eprod_type'(CORR_DIV - 1) : eprod_type'(0));
      decay = value_type'(adj[CORR_SHIFT +: VAL_W]);
      sum   = new_type'(entry) + new_type'(bonus) - new_type'(decay);
      if (sum > new_type'(32767)) begin
         return value_type'(16'sh7FFF);
      end else if (sum < new_type'(-32768)) begin
         return value_type'(16'sh8000);
      end
      return value_type'(sum[VAL_W-1:0]);
   endfunction

endpackage

### rtl/ech_ctrl.sv
// Sequencer for the correction history block: clearing pass, word intake and step timing.
// Depends on ech_pkg for the state, command and status types.
module ech_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  ech_pkg::status_type status,
   output ech_pkg::cmd_type    cmd,
   output logic                req_stall
);

   ech_pkg::state_type state_ff;
   ech_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ech_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ech_pkg::ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ech_pkg::ST_IDLE;
            end
         end
         ech_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ech_pkg::ST_STEP1;
            end
         end
         ech_pkg::ST_STEP1: state_in = ech_pkg::ST_STEP2;
         ech_pkg::ST_STEP2: state_in = ech_pkg::ST_STEP3;
         ech_pkg::ST_STEP3: state_in = ech_pkg::ST_STEP4;
         ech_pkg::ST_STEP4: state_in = ech_pkg::ST_STEP5;
         ech_pkg::ST_STEP5: begin
            state_in = status.out_busy ? ech_pkg::ST_HOLD : ech_pkg::ST_IDLE;
         end
         ech_pkg::ST_HOLD: begin
            if (!status.out_busy) begin
               state_in = ech_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ech_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
         ech_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ech_pkg::ST_STEP1, ech_pkg::ST_STEP2, ech_pkg::ST_STEP3: begin
         end
         ech_pkg::ST_STEP4: cmd.table_wr = status.is_update;
         ech_pkg::ST_STEP5, ech_pkg::ST_HOLD: cmd.load_out = !status.out_busy;
      endcase
   end

   // A captured word passes steps 1 to 4 and then reaches the result step.
   a_step_timing: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> ##5 (state_ff == ech_pkg::ST_STEP5))
      else $error("result step not reached five cycles after capture");

   // The clearing pass stops after the last entry.
   a_clear_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.clear_wr && status.clear_done) |=> !cmd.clear_wr)
      else $error("clearing pass ran past the last entry");

   // No word is taken right after reset; the tables are still being cleared.
   a_reset_stall: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("input not stalled after reset");

endmodule

### rtl/ech_datapath.sv
// Datapath for the correction history block: three entry tables, query and update arithmetic,
// and the result register. Depends on ech_pkg; driven by commands from ech_ctrl.
module ech_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ech_pkg::cmd_type                cmd,
   input  ech_pkg::cfg_type                cfg,
   input  logic [1:0]                      req_type,
   input  logic                            req_side,
   input  logic [ech_pkg::KEY_W-1:0]       req_pawn_index,
   input  logic [ech_pkg::KEY_W-1:0]       req_white_index,
   input  logic [ech_pkg::KEY_W-1:0]       req_black_index,
   input  logic signed [ech_pkg::VAL_W-1:0] req_static_eval,
   input  logic signed [ech_pkg::VAL_W-1:0] req_search_score,
   input  logic [7:0]                      req_depth,
   input  logic [7:0]                      req_fifty_count,
   input  logic                            rsp_stall,
   output ech_pkg::status_type             status,
   output logic                            rsp_valid,
   output logic signed [ech_pkg::VAL_W-1:0] rsp_value
);

   // Captured word.
   logic [1:0]                       type_ff;
   logic [ech_pkg::ADDR_W-1:0]       pawn_addr_ff;
   logic [ech_pkg::ADDR_W-1:0]       white_addr_ff;
   logic [ech_pkg::ADDR_W-1:0]       black_addr_ff;
   logic signed [ech_pkg::VAL_W-1:0] eval_ff;
   logic signed [ech_pkg::VAL_W-1:0] score_ff;
   logic [7:0]                       depth_ff;
   logic [7:0]                       fifty_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff       <= req_type;
         pawn_addr_ff  <= ech_pkg::table_addr(req_side, req_pawn_index);
         white_addr_ff <= ech_pkg::table_addr(req_side, req_white_index);
         black_addr_ff <= ech_pkg::table_addr(req_side, req_black_index);
         eval_ff       <= req_static_eval;
         score_ff      <= req_search_score;
         depth_ff      <= req_depth;
         fifty_ff      <= req_fifty_count;
      end
   end

   // Clearing pass address.
   logic [ech_pkg::ADDR_W-1:0] clear_addr_ff;
   logic [ech_pkg::ADDR_W-1:0] clear_addr_in;

   assign clear_addr_in = clear_addr_ff + ech_pkg::ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Tables. Reads happen on the capture edge, straight from the request ports.
   logic signed [ech_pkg::VAL_W-1:0] pawn_mem  [ech_pkg::DEPTH];
   logic signed [ech_pkg::VAL_W-1:0] white_mem [ech_pkg::DEPTH];
   logic signed [ech_pkg::VAL_W-1:0] black_mem [ech_pkg::DEPTH];

   logic signed [ech_pkg::VAL_W-1:0] pawn_rd_ff;
   logic signed [ech_pkg::VAL_W-1:0] white_rd_ff;
   logic signed [ech_pkg::VAL_W-1:0] black_rd_ff;

   logic                             wr_en;
   logic [ech_pkg::ADDR_W-1:0]       pawn_wr_addr;
   logic [ech_pkg::ADDR_W-1:0]       white_wr_addr;
   logic [ech_pkg::ADDR_W-1:0]       black_wr_addr;
   logic signed [ech_pkg::VAL_W-1:0] pawn_wr_data;
   logic signed [ech_pkg::VAL_W-1:0] white_wr_data;
   logic signed [ech_pkg::VAL_W-1:0] black_wr_data;
   logic signed [ech_pkg::VAL_W-1:0] pawn_new;
   logic signed [ech_pkg::VAL_W-1:0] white_new;
   logic signed [ech_pkg::VAL_W-1:0] black_new;

   assign wr_en         = cmd.clear_wr | cmd.table_wr;
   assign pawn_wr_addr  = cmd.clear_wr ? clear_addr_ff : pawn_addr_ff;
   assign white_wr_addr = cmd.clear_wr ? clear_addr_ff : white_addr_ff;
   assign black_wr_addr = cmd.clear_wr ? clear_addr_ff : black_addr_ff;
   assign pawn_wr_data  = cmd.clear_wr ? '0 : pawn_new;
   assign white_wr_data = cmd.clear_wr ? '0 : white_new;
   assign black_wr_data = cmd.clear_wr ? '0 : black_new;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pawn_mem[pawn_wr_addr] <= pawn_wr_data;
      end
      if (cmd.capture) begin
         pawn_rd_ff <= pawn_mem[ech_pkg::table_addr(req_side, req_pawn_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         white_mem[white_wr_addr] <= white_wr_data;
      end
      if (cmd.capture) begin
         white_rd_ff <= white_mem[ech_pkg::table_addr(req_side, req_white_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         black_mem[black_wr_addr] <= black_wr_data;
      end
      if (cmd.capture) begin
         black_rd_ff <= black_mem[ech_pkg::table_addr(req_side, req_black_index)];
      end
   end

   // The stage registers below load every cycle. Their captured sources hold still from capture to
   // result, so each stage settles in the cycle after the one before it.

   // Step 1: weighted entries, scaler product and raw bonus product.
   logic signed [8:0]  pw_s;
   logic signed [8:0]  nw_s;
   logic signed [9:0]  scale_num;
   logic signed [16:0] diff;

   ech_pkg::prod_type pawn_prod_ff, white_prod_ff, black_prod_ff;
   ech_pkg::prod_type pawn_prod_in, white_prod_in, black_prod_in;
   ech_pkg::wide_type scale_prod_ff, scale_prod_in;
   ech_pkg::wide_type raw_ff, raw_in;

   assign pw_s      = $signed({1'b0, cfg.pawn_weight});
   assign nw_s      = $signed({1'b0, cfg.non_pawn_weight});
   assign scale_num = $signed({1'b0, cfg.fifty_scaling}) - $signed({2'b00, fifty_ff});
   assign diff      = $signed({score_ff[ech_pkg::VAL_W-1], score_ff})
                    - $signed({eval_ff[ech_pkg::VAL_W-1], eval_ff});

   assign pawn_prod_in  = ech_pkg::prod_type'(pawn_rd_ff) * ech_pkg::prod_type'(pw_s);
   assign white_prod_in = ech_pkg::prod_type'(white_rd_ff) * ech_pkg::prod_type'(nw_s);
   assign black_prod_in = ech_pkg::prod_type'(black_rd_ff) * ech_pkg::prod_type'(nw_s);
   assign scale_prod_in = ech_pkg::wide_type'(eval_ff) * ech_pkg::wide_type'(scale_num);
   assign raw_in        = ech_pkg::wide_type'(diff)
                        * ech_pkg::wide_type'($signed({1'b0, depth_ff}));

   always_ff @(posedge clock) begin
      pawn_prod_ff  <= pawn_prod_in;
      white_prod_ff <= white_prod_in;
      black_prod_ff <= black_prod_in;
      scale_prod_ff <= scale_prod_in;
      raw_ff        <= raw_in;
   end

   // Step 2: correction, scaler magnitude over 8, and clamped bonus magnitude.
   ech_pkg::sum_type  corr_sum;
   ech_pkg::sum_type  corr_adj;
   ech_pkg::wide_type scale_mag;
   ech_pkg::wide_type raw_mag;
   logic [ech_pkg::Y_W-1:0]          raw_div;

   logic signed [ech_pkg::VAL_W-1:0] corr_ff, corr_in;
   logic [ech_pkg::Y_W-1:0]          y_ff, y_in;
   logic                             sneg_ff;
   logic [ech_pkg::LIMIT_W-1:0]      bonus_mag_ff, bonus_mag_in;
   logic                             bonus_neg_ff;

   assign corr_sum  = ech_pkg::sum_type'(pawn_prod_ff) + ech_pkg::sum_type'(white_prod_ff)
                    + ech_pkg::sum_type'(black_prod_ff);
   // Truncation toward zero: bias negative sums before the shift.
   assign corr_adj  = corr_sum + (corr_sum[ech_pkg::SUM_W-1]
                    ? ech_pkg::sum_type'(ech_pkg::CORR_DIV - 1) : ech_pkg::sum_type'(0));
   assign corr_in   = corr_adj[ech_pkg::CORR_SHIFT +: ech_pkg::VAL_W];

   assign scale_mag = scale_prod_ff[ech_pkg::WIDE_W-1] ? -scale_prod_ff : scale_prod_ff;
   assign y_in      = scale_mag[ech_pkg::SCALE_PRE_SHIFT +: ech_pkg::Y_W];

   assign raw_mag   = raw_ff[ech_pkg::WIDE_W-1] ? -raw_ff : raw_ff;
   assign raw_div   = raw_mag[ech_pkg::BONUS_SHIFT +: ech_pkg::Y_W];
   assign bonus_mag_in = (raw_div > ech_pkg::Y_W'(cfg.bonus_limit))
                       ? cfg.bonus_limit : raw_div[ech_pkg::LIMIT_W-1:0];

   always_ff @(posedge clock) begin
      corr_ff      <= corr_in;
      y_ff         <= y_in;
      sneg_ff      <= scale_prod_ff[ech_pkg::WIDE_W-1];
      bonus_mag_ff <= bonus_mag_in;
      bonus_neg_ff <= raw_ff[ech_pkg::WIDE_W-1];
   end

   // Step 3: reciprocal estimate of y/25, signed bonus and entry decay products.
   ech_pkg::recip_type recip_prod;
   logic signed [ech_pkg::BONUS_W-1:0] mag_s;

   logic [ech_pkg::Q_W-1:0]            q0_ff, q0_in;
   logic signed [ech_pkg::BONUS_W-1:0] bonus_ff, bonus_in;
   ech_pkg::eprod_type pawn_eprod_ff, white_eprod_ff, black_eprod_ff;
   ech_pkg::eprod_type pawn_eprod_in, white_eprod_in, black_eprod_in;

   assign recip_prod = ech_pkg::recip_type'(y_ff) * ech_pkg::recip_type'(ech_pkg::DIV25_MUL);
   assign q0_in      = recip_prod[ech_pkg::DIV25_SHIFT +: ech_pkg::Q_W];
   assign mag_s      = $signed({1'b0, bonus_mag_ff});
   assign bonus_in   = bonus_neg_ff ? -mag_s : mag_s;

   assign pawn_eprod_in  = ech_pkg::eprod_type'(pawn_rd_ff) * ech_pkg::eprod_type'(mag_s);
   assign white_eprod_in = ech_pkg::eprod_type'(white_rd_ff) * ech_pkg::eprod_type'(mag_s);
   assign black_eprod_in = ech_pkg::eprod_type'(black_rd_ff) * ech_pkg::eprod_type'(mag_s);

   always_ff @(posedge clock) begin
      q0_ff          <= q0_in;
      bonus_ff       <= bonus_in;
      pawn_eprod_ff  <= pawn_eprod_in;
      white_eprod_ff <= white_eprod_in;
      black_eprod_ff <= black_eprod_in;
   end

   // Step 4: the estimate is low by at most one, so one compare fixes the quotient.
   // Updated entries are formed here and written at the end of this step.
   ech_pkg::rem_type         q0_x25;
   ech_pkg::rem_type         rem;
   logic [ech_pkg::Q_W-1:0]  q_fix;
   ech_pkg::scaled_type      q_s;
   ech_pkg::scaled_type      scaled_ff, scaled_in;

   assign q0_x25    = ech_pkg::rem_type'(q0_ff) * ech_pkg::rem_type'(ech_pkg::SCALE_POST_DIV);
   assign rem       = ech_pkg::rem_type'(y_ff) - q0_x25;
   assign q_fix     = q0_ff + ech_pkg::Q_W'(rem >= ech_pkg::rem_type'(ech_pkg::SCALE_POST_DIV));
   assign q_s       = $signed({1'b0, q_fix});
   assign scaled_in = sneg_ff ? -q_s : q_s;

   assign pawn_new  = ech_pkg::apply_bonus(pawn_rd_ff, bonus_ff, pawn_eprod_ff);
   assign white_new = ech_pkg::apply_bonus(white_rd_ff, bonus_ff, white_eprod_ff);
   assign black_new = ech_pkg::apply_bonus(black_rd_ff, bonus_ff, black_eprod_ff);

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

   // Step 5: result selection and the output register.
   ech_pkg::total_type               total;
   logic signed [ech_pkg::VAL_W-1:0] adjusted;
   logic signed [ech_pkg::VAL_W-1:0] result;
   logic                             rsp_valid_ff;
   logic signed [ech_pkg::VAL_W-1:0] rsp_value_ff;

   assign total = ech_pkg::total_type'(scaled_ff) + ech_pkg::total_type'(corr_ff);

   always_comb begin
      priority if (total > ech_pkg::total_type'(ech_pkg::MATE_MAX)) begin
         adjusted = ech_pkg::VAL_W'(ech_pkg::MATE_MAX);
      end else if (total < -ech_pkg::total_type'(ech_pkg::MATE_MAX)) begin
         adjusted = -ech_pkg::VAL_W'(ech_pkg::MATE_MAX);
      end else begin
         adjusted = total[ech_pkg::VAL_W-1:0];
      end
   end

   always_comb begin
      unique case (type_ff)
         ech_pkg::REQ_ADJUST: result = adjusted;
         ech_pkg::REQ_CORR:   result = corr_ff;
         ech_pkg::REQ_UPDATE: result = ech_pkg::value_type'(bonus_ff);
         default:             result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_value_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   assign status.clear_done = (clear_addr_ff == ech_pkg::ADDR_W'(ech_pkg::DEPTH - 1));
   assign status.out_busy   = rsp_valid_ff & rsp_stall;
   assign status.is_update  = (type_ff == ech_pkg::REQ_UPDATE);

   // The bonus applied to the tables stays within the configured limit.
   a_bonus_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.table_wr |-> (bonus_mag_ff <= cfg.bonus_limit))
      else $error("update bonus exceeds the configured limit");

endmodule

### rtl/eval_correction_history_top.sv
// Evaluation correction history: configuration registers, sequencer and datapath.
// rsp_valid rises when the result register loads, in step 5 or, after a stall, the hold state.
// A new word is taken only in the idle state, once the last word's result has been loaded.
// Every word reads one entry from each table on intake; an update writes them back in step 4.
// Reset: a clearing pass zeroes every entry of all three tables, with req_stall held high;
// configuration writes are taken throughout. Depends on ech_pkg, ech_ctrl and ech_datapath.
module eval_correction_history_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic                                req_side,
   input  logic [ech_pkg::KEY_W-1:0]           req_pawn_index,
   input  logic [ech_pkg::KEY_W-1:0]           req_white_index,
   input  logic [ech_pkg::KEY_W-1:0]           req_black_index,
   input  logic signed [ech_pkg::VAL_W-1:0]    req_static_eval,
   input  logic signed [ech_pkg::VAL_W-1:0]    req_search_score,
   input  logic [7:0]                          req_depth,
   input  logic [7:0]                          req_fifty_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ech_pkg::VAL_W-1:0]    rsp_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ech_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ech_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ech_pkg::cfg_type    cfg_ff;
   ech_pkg::cfg_type    cfg_in;
   ech_pkg::cmd_type    cmd;
   ech_pkg::status_type status;

   assign csr_ready = 1'b1;

   // Writes to indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ech_pkg::CSR_PAWN_WEIGHT:     cfg_in.pawn_weight     = csr_wdata[7:0];
            ech_pkg::CSR_NON_PAWN_WEIGHT: cfg_in.non_pawn_weight = csr_wdata[7:0];
            ech_pkg::CSR_BONUS_LIMIT:     cfg_in.bonus_limit     = csr_wdata[9:0];
            ech_pkg::CSR_FIFTY_SCALING:   cfg_in.fifty_scaling   = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ech_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ech_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   ech_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .req_type         (req_type),
      .req_side         (req_side),
      .req_pawn_index   (req_pawn_index),
      .req_white_index  (req_white_index),
      .req_black_index  (req_black_index),
      .req_static_eval  (req_static_eval),
      .req_search_score (req_search_score),
      .req_depth        (req_depth),
      .req_fifty_count  (req_fifty_count),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value)
   );

endmodule

### bench/correction_checker.sv
// Checker for the evaluation correction history block: watches the request, result and
// register channels, predicts each result word from its own copy of the tables, and compares.
// Depends on ech_pkg only.
module correction_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic                             req_side,
   input  logic [ech_pkg::KEY_W-1:0]        req_pawn_index,
   input  logic [ech_pkg::KEY_W-1:0]        req_white_index,
   input  logic [ech_pkg::KEY_W-1:0]        req_black_index,
   input  logic signed [ech_pkg::VAL_W-1:0] req_static_eval,
   input  logic signed [ech_pkg::VAL_W-1:0] req_search_score,
   input  logic [7:0]                       req_depth,
   input  logic [7:0]                       req_fifty_count,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [ech_pkg::VAL_W-1:0] rsp_value,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ech_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ech_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               fail_count,
   output int                               pending
);
   import ech_pkg::*;

   localparam int BONUS_DIV = 8;

   value_type pawn_entries  [DEPTH];
   value_type white_entries [DEPTH];
   value_type black_entries [DEPTH];
   cfg_type   cfg_now;
   value_type expected_values [$];
   value_type want;

   task automatic report_mismatch(input string what, input value_type got,
                                  input value_type wanted);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
      fail_count++;
   endtask

   // The entry moves toward the bonus and decays by its own share; saturated to 16 bits.
   function automatic value_type decayed_entry(input value_type entry, input longint bonus);
      longint mag;
      longint next;
      mag  = (bonus < 0) ? -bonus : bonus;
      next = longint'(entry) + bonus - (longint'(entry) * mag) / CORR_DIV;
      if (next > 32767) begin
         next = 32767;
      end else if (next < -32768) begin
         next = -32768;
      end
      return value_type'(next);
   endfunction

   function automatic value_type predict_value(input logic [1:0] kind, input logic side,
                                               input logic [KEY_W-1:0] pawn_idx,
                                               input logic [KEY_W-1:0] white_key,
                                               input logic [KEY_W-1:0] black_key,
                                               input value_type eval, input value_type score,
                                               input logic [7:0] depth,
                                               input logic [7:0] fifty);
      int     ps;
      int     ws;
      int     bs;
      longint corr;
      longint scaled;
      longint bonus;
      longint lim;
      longint outcome;
      ps = int'(side) * TABLE_ENTRIES + int'(pawn_idx) % TABLE_ENTRIES;
      ws = int'(side) * TABLE_ENTRIES + int'(white_key) % TABLE_ENTRIES;
      bs = int'(side) * TABLE_ENTRIES + int'(black_key) % TABLE_ENTRIES;
      outcome = 0;
      case (kind)
         REQ_ADJUST, REQ_CORR: begin
            corr = (longint'(pawn_entries[ps]) * longint'(cfg_now.pawn_weight)
                    + longint'(white_entries[ws]) * longint'(cfg_now.non_pawn_weight)
                    + longint'(black_entries[bs]) * longint'(cfg_now.non_pawn_weight))
                   / CORR_DIV;
            if (kind == REQ_CORR) begin
               outcome = corr;
            end else begin
               // The scaler numerator goes negative when the clock passes the base.
               scaled  = longint'(eval)
                         * (longint'(cfg_now.fifty_scaling) - longint'(fifty)) / SCALE_DIV;
               outcome = scaled + corr;
               if (outcome > MATE_MAX) begin
                  outcome = MATE_MAX;
               end else if (outcome < -MATE_MAX) begin
                  outcome = -MATE_MAX;
               end
            end
         end
         REQ_UPDATE: begin
            lim   = longint'(cfg_now.bonus_limit);
            bonus = (longint'(score) - longint'(eval)) * longint'(depth) / BONUS_DIV;
            if (bonus > lim) begin
               bonus = lim;
            end else if (bonus < -lim) begin
               bonus = -lim;
            end
            pawn_entries[ps]  = decayed_entry(pawn_entries[ps], bonus);
            white_entries[ws] = decayed_entry(white_entries[ws], bonus);
            black_entries[bs] = decayed_entry(black_entries[bs], bonus);
            outcome = bonus;
         end
         default: outcome = 0;
      endcase
      return value_type'(outcome);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_now    = CFG_RESET;
         fail_count = 0;
         expected_values.delete();
         for (int i = 0; i < DEPTH; i++) begin
            pawn_entries[i]  = '0;
            white_entries[i] = '0;
            black_entries[i] = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAWN_WEIGHT:     cfg_now.pawn_weight     = csr_wdata[7:0];
               CSR_NON_PAWN_WEIGHT: cfg_now.non_pawn_weight = csr_wdata[7:0];
               CSR_BONUS_LIMIT:     cfg_now.bonus_limit     = csr_wdata[LIMIT_W-1:0];
               CSR_FIFTY_SCALING:   cfg_now.fifty_scaling   = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_value, '0);
            end else begin
               want = expected_values.pop_front();
               if (rsp_value !== want) begin
                  report_mismatch("value", rsp_value, want);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_values.push_back(predict_value(req_type, req_side, req_pawn_index,
                                                    req_white_index, req_black_index,
                                                    req_static_eval, req_search_score,
                                                    req_depth, req_fifty_count));
         end
      end
      pending = expected_values.size();
   end

endmodule

### bench/testbench.sv
// Testbench top for the evaluation correction history block: drives request and register
// words, stalls the result channel at random, and gives the verdict.
// Depends on ech_pkg, eval_correction_history_top and correction_checker.
module testbench;
   import ech_pkg::*;

   localparam int         RESET_CYCLES       = 11;
   localparam int         PHASES             = 5;
   localparam int         ITEMS_PER_PHASE    = 200;
   localparam int         RSP_HOLD_CYCLES    = 300;
   localparam int         TAIL_CYCLES        = 12;
   localparam int         WATCHDOG_LIMIT     = 100000;
   localparam logic [1:0] REQ_UNUSED         = 2'd3;
   localparam int         CSR_FIRST_UNMAPPED = 4;
   localparam int         CSR_LAST_INDEX     = 15;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_type;
   logic                  req_side;
   logic [KEY_W-1:0]      req_pawn_index;
   logic [KEY_W-1:0]      req_white_index;
   logic [KEY_W-1:0]      req_black_index;
   value_type             req_static_eval;
   value_type             req_search_score;
   logic [7:0]            req_depth;
   logic [7:0]            req_fifty_count;
   logic                  rsp_valid;
   logic                  rsp_stall;
   value_type             rsp_value;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   fail_count;
   int   pending;
   int   quiet_cycles;
   logic idle_on;
   logic hold_rsp_req;

   eval_correction_history_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_side         (req_side),
      .req_pawn_index   (req_pawn_index),
      .req_white_index  (req_white_index),
      .req_black_index  (req_black_index),
      .req_static_eval  (req_static_eval),
      .req_search_score (req_search_score),
      .req_depth        (req_depth),
      .req_fifty_count  (req_fifty_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   correction_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_side         (req_side),
      .req_pawn_index   (req_pawn_index),
      .req_white_index  (req_white_index),
      .req_black_index  (req_black_index),
      .req_static_eval  (req_static_eval),
      .req_search_score (req_search_score),
      .req_depth        (req_depth),
      .req_fifty_count  (req_fifty_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Result side: short random stalls, plus one long hold-off when asked for.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= idle_on && ($urandom_range(99) < 6);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] pawn_w,
                             input logic [CSR_DATA_W-1:0] non_pawn_w,
                             input logic [CSR_DATA_W-1:0] limit,
                             input logic [CSR_DATA_W-1:0] scaling);
      write_reg(CSR_PAWN_WEIGHT, pawn_w);
      write_reg(CSR_NON_PAWN_WEIGHT, non_pawn_w);
      write_reg(CSR_BONUS_LIMIT, limit);
      write_reg(CSR_FIFTY_SCALING, scaling);
   endtask

   // Leaves the request channel quiet until every expected result word has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   task automatic send_word(input logic [1:0] kind, input logic side,
                            input logic [KEY_W-1:0] pawn_idx,
                            input logic [KEY_W-1:0] white_key,
                            input logic [KEY_W-1:0] black_key,
                            input value_type eval, input value_type score,
                            input logic [7:0] depth, input logic [7:0] fifty);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_side         <= side;
      req_pawn_index   <= pawn_idx;
      req_white_index  <= white_key;
      req_black_index  <= black_key;
      req_static_eval  <= eval;
      req_search_score <= score;
      req_depth        <= depth;
      req_fifty_count  <= fifty;
      do @(posedge clock); while (req_stall);
   endtask

   // Most keys come from a few hot slots so that queries see entries that updates touched.
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 80) begin
         case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 14'h1555;
            default: return 14'h2AAA;
         endcase
      end
      return KEY_W'($urandom);
   endfunction

   task automatic random_word();
      int         roll;
      logic [1:0] kind;
      value_type  eval;
      value_type  score;
      logic [7:0] depth;
      roll = $urandom_range(99);
      if (roll < 45) begin
         kind = REQ_UPDATE;
      end else if (roll < 70) begin
         kind = REQ_ADJUST;
      end else if (roll < 95) begin
         kind = REQ_CORR;
      end else begin
         kind = REQ_UNUSED;
      end
      if ($urandom_range(99) < 70) begin
         eval = value_type'(int'($urandom_range(4000)) - 2000);
      end else begin
         eval = value_type'($urandom);
      end
      if ($urandom_range(99) < 60) begin
         score = value_type'(int'(eval) + int'($urandom_range(600)) - 300);
      end else begin
         score = value_type'($urandom);
      end
      if ($urandom_range(1) == 1) begin
         depth = 8'($urandom_range(16));
      end else begin
         depth = 8'($urandom);
      end
      send_word(kind, 1'($urandom), pick_key(), pick_key(), pick_key(), eval, score, depth,
                8'($urandom));
   endtask

   initial begin
      int phase;
      int n;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = '0;
      req_side         = 1'b0;
      req_pawn_index   = '0;
      req_white_index  = '0;
      req_black_index  = '0;
      req_static_eval  = '0;
      req_search_score = '0;
      req_depth        = '0;
      req_fifty_count  = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      idle_on          = 1'b1;
      hold_rsp_req     = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Taken during the clearing pass; an unmapped index must change nothing.
      write_reg(CSR_IDX_W'($urandom_range(CSR_LAST_INDEX, CSR_FIRST_UNMAPPED)),
                CSR_DATA_W'($urandom));

      // Directed words under the reset settings.
      send_word(REQ_ADJUST, 1'b0, '0, '0, '0, 16'sh7FFF, '0, '0, '0);
      send_word(REQ_ADJUST, 1'b1, '1, '1, '1, 16'sh8000, '0, '0, 8'd255);
      send_word(REQ_CORR, 1'b0, '0, '0, '0, '0, '0, '0, '0);
      send_word(REQ_UPDATE, 1'b0, '0, '0, '0, 16'sh8000, 16'sh7FFF, 8'd255, '0);
      send_word(REQ_UPDATE, 1'b1, '1, '1, '1, 16'sh7FFF, 16'sh8000, 8'd255, 8'd255);
      send_word(REQ_CORR, 1'b0, '0, '0, '0, '0, '0, '0, '0);
      send_word(REQ_CORR, 1'b1, '1, '1, '1, '0, '0, '0, '0);
      send_word(REQ_ADJUST, 1'b0, '0, '0, '0, 16'sd1000, '0, '0, 8'd187);
      send_word(REQ_UPDATE, 1'b0, '0, '0, '0, '0, 16'sd500, '0, '0);
      send_word(REQ_UPDATE, 1'b0, '0, '0, '0, '0, 16'sd100, 8'd1, '0);
      send_word(REQ_UPDATE, 1'b0, '0, '0, '0, '0, -16'sd9, 8'd1, '0);
      send_word(REQ_UPDATE, 1'b0, '0, '0, '0, '0, -16'sd7, 8'd1, '0);
      send_word(REQ_UNUSED, 1'b1, '1, '1, '1, 16'sh7FFF, 16'sh7FFF, 8'd255, 8'd255);
      send_word(REQ_CORR, 1'b1, '1, '1, '1, '0, '0, '0, '0);
      // Back-to-back updates on the same entries exercise read-after-write.
      send_word(REQ_UPDATE, 1'b0, 14'h155, 14'h2AA, 14'h155, '0, 16'sd200, 8'd20, '0);
      send_word(REQ_UPDATE, 1'b0, 14'h155, 14'h2AA, 14'h155, '0, -16'sd150, 8'd30, '0);
      send_word(REQ_UPDATE, 1'b0, 14'h155, 14'h155, 14'h2AA, 16'sd50, 16'sd400, 8'd3, '0);
      send_word(REQ_CORR, 1'b0, 14'h155, 14'h2AA, 14'h155, '0, '0, '0, '0);
      send_word(REQ_ADJUST, 1'b0, 14'h155, 14'h2AA, 14'h155, 16'sh8000, '0, '0, '0);
      send_word(REQ_CORR, 1'b1, 14'h155, 14'h2AA, 14'h155, '0, '0, '0, '0);
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       set_config(10'd36, 10'd23, 10'd341, 10'd187);
            1:       set_config('1, '1, '1, '1);
            2:       set_config('0, '0, '0, '0);
            default: set_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                                CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         endcase
         write_reg(CSR_IDX_W'($urandom_range(CSR_LAST_INDEX, CSR_FIRST_UNMAPPED)),
                   CSR_DATA_W'($urandom));
         // One phase runs without any idling on either side.
         idle_on = (phase != 3);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == 40) begin
               hold_rsp_req = 1'b1;
            end
            if (n == ITEMS_PER_PHASE / 2) begin
               drain();
            end
            random_word();
         end
         drain();
      end

      idle_on = 1'b1;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
